// ----- sv/dmc_pkg.sv -----
// dmc_pkg: shared types, codes and helper functions of the depth-first maze carver
// no dependencies; used by the channel interfaces and every module of the block but dmc_cell_mem
package dmc_pkg;

    localparam int COORD_W = 6;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // event codes
    localparam logic [1:0] EV_ADVANCE = 2'd0;
    localparam logic [1:0] EV_BACK    = 2'd1;
    localparam logic [1:0] EV_IDLE    = 2'd2;
    localparam logic [1:0] EV_READ    = 2'd3;

    // register select, taken from paddr[2]
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [COORD_W-1:0] GRID_RST = 6'd31;

    // bit positions in a cell word
    localparam int VIS_BIT   = 0;
    localparam int CARVE_BIT = 1;

    // neighbour order east, west, south, north
    localparam logic signed [7:0] STEP_DR [4] = '{8'sd0, 8'sd0, 8'sd2, -8'sd2};
    localparam logic signed [7:0] STEP_DC [4] = '{8'sd2, -8'sd2, 8'sd0, 8'sd0};
    localparam logic signed [7:0] WALL_DR [4] = '{8'sd0, 8'sd0, 8'sd1, -8'sd1};
    localparam logic signed [7:0] WALL_DC [4] = '{8'sd1, -8'sd1, 8'sd0, 8'sd0};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_PICK,
        ST_QRY,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         random_value;
        logic [COORD_W-1:0] query_row;
        logic [COORD_W-1:0] query_col;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] top_col;
        logic [COORD_W-1:0] wall_row;
        logic [COORD_W-1:0] wall_col;
        logic               cell_open;
        logic               done_res;
    } t_rsp_item;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_coord;

    typedef struct packed {
        logic [COORD_W-1:0] grid_rows;
        logic [COORD_W-1:0] grid_cols;
    } t_cfg;

    // value mod 3 by summing base-4 digits, then two conditional subtracts
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // random byte mod a candidate count of one to four
    function automatic logic [1:0] pick_index(input logic [7:0] v, input logic [2:0] n);
        logic [1:0] res;
        case (n)
            3'd2:    res = {1'b0, v[0]};
            3'd3:    res = mod3(v);
            3'd4:    res = v[1:0];
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    // neighbour inside both the configured grid border and the store
    function automatic logic nb_ok(
        input logic signed [7:0] r,
        input logic signed [7:0] c,
        input logic [COORD_W-1:0] gr,
        input logic [COORD_W-1:0] gc,
        input int max_r,
        input int max_c
    );
        logic signed [7:0] lim_r;
        logic signed [7:0] lim_c;
        lim_r = $signed({2'b00, gr}) - 8'sd2;
        lim_c = $signed({2'b00, gc}) - 8'sd2;
        return (r >= 8'sd1) && (c >= 8'sd1) && (r <= lim_r) && (c <= lim_c)
            && (int'(r) < max_r) && (int'(c) < max_c);
    endfunction

endpackage

// ----- sv/dmc_chan_if.sv -----
// dmc_req_if / dmc_rsp_if: valid-ready channels of the maze carver
// depends on dmc_pkg for the request and result item types
interface dmc_req_if;
    logic                valid;
    logic                ready;
    dmc_pkg::t_req_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dmc_rsp_if;
    logic                valid;
    logic                ready;
    dmc_pkg::t_rsp_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/dmc_cfg_regs.sv -----
// dmc_cfg_regs: apb register file holding the grid height and width
// depends on dmc_pkg for the register map and the t_cfg struct
module dmc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0]   paddr,
    input  logic [dmc_pkg::PDATA_W-1:0]   pwdata,
    output logic [dmc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output dmc_pkg::t_cfg                 o_cfg
);

    logic [dmc_pkg::COORD_W-1:0] r_grid_rows;
    logic [dmc_pkg::COORD_W-1:0] r_grid_cols;
    logic                        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= dmc_pkg::GRID_RST;
            r_grid_cols <= dmc_pkg::GRID_RST;
        end else if (w_wr) begin
            if (paddr[2] == dmc_pkg::REG_GRID_ROWS) begin
                r_grid_rows <= pwdata[dmc_pkg::COORD_W-1:0];
            end else begin
                r_grid_cols <= pwdata[dmc_pkg::COORD_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dmc_pkg::REG_GRID_ROWS) begin
            prdata = dmc_pkg::PDATA_W'(r_grid_rows);
        end else begin
            prdata = dmc_pkg::PDATA_W'(r_grid_cols);
        end
    end

    assign o_cfg.grid_rows = r_grid_rows;
    assign o_cfg.grid_cols = r_grid_cols;

endmodule

// ----- sv/dmc_cell_mem.sv -----
// dmc_cell_mem: cell store, one word per grid cell holding visited and carved bits
// synchronous read, per-bit write mask; uses no package items
module dmc_cell_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata,
    input  logic          i_we,
    input  logic [1:0]    i_wmask,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < 2; b++) begin
                if (i_wmask[b]) begin
                    mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dmc_stack_mem.sv -----
// dmc_stack_mem: path stack entries below the cached top of stack
// synchronous read; depends on dmc_pkg for t_coord
module dmc_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output dmc_pkg::t_coord o_rdata,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dmc_pkg::t_coord i_wdata
);

    dmc_pkg::t_coord mem [DEPTH];
    dmc_pkg::t_coord r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dfs_maze_carver.sv -----
// dfs_maze_carver: randomized depth-first maze carver, sequencer and result register
// depends on dmc_pkg, dmc_chan_if, dmc_cfg_regs, dmc_cell_mem and dmc_stack_mem
//
//   channel   direction  kind        payload
//   i_req     in         valid/ready cmd, random_value, query_row, query_col
//   o_rsp     out        valid/ready event_res, top/wall coords, cell_open, done_res
//   apb       in/out     psel/penable grid_rows at 0x0, grid_cols at 0x4
//
// a step request on a non-empty stack runs four neighbour reads through the single
// cell-store read port, a wait state for the read latency, the pick/write-back state and
// the result state; a read request runs a query state and then the result state
// after reset and on restart the cell store is swept one entry a cycle;
// no request is taken meanwhile, apb writes still are
// a finished result sits in the output register; the next request is taken while it waits
module dfs_maze_carver #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dmc_req_if.sink                     i_req,
    dmc_rsp_if.source                   o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0] paddr,
    input  logic [dmc_pkg::PDATA_W-1:0] pwdata,
    output logic [dmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CAW   = $clog2(CELLS);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int CNTW  = $clog2(STACK_DEPTH + 1);
    localparam int CW    = dmc_pkg::COORD_W;

    function automatic logic [CAW-1:0] cell_addr(input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        logic [31:0] full;
        full = 32'(row) * 32'(MAX_COLS) + 32'(col);
        return full[CAW-1:0];
    endfunction

    dmc_pkg::t_state    r_state, n_state;
    dmc_pkg::t_cfg      w_cfg;

    logic [CAW-1:0]     r_clr;
    logic               r_clr_reply;
    logic [1:0]         r_k;
    logic [CW-1:0]      r_top_row, r_top_col;
    logic [CNTW-1:0]    r_count;
    logic               r_out_valid;

    logic [1:0]         r_cmd;
    logic [7:0]         r_rnd;
    logic [CW-1:0]      r_qrow, r_qcol;
    logic [3:0]         r_vis;
    logic [1:0]         r_ev;
    logic [CW-1:0]      r_wall_row, r_wall_col;
    dmc_pkg::t_rsp_item r_out;

    logic               w_accept;
    logic               w_clr_last;
    logic               w_out_load;
    logic               w_q_in_store;
    logic [CNTW-1:0]    w_cnt_m1, w_cnt_m2;
    logic               w_not_full;

    logic signed [7:0]  w_nb_row [4];
    logic signed [7:0]  w_nb_col [4];
    logic [3:0]         w_nb_ok;
    logic [3:0]         w_cand;
    logic [2:0]         w_n;
    logic [1:0]         w_idx;
    logic [1:0]         w_pick;
    logic               w_adv;
    logic [CW-1:0]      w_new_wall_row, w_new_wall_col;
    logic signed [7:0]  w_wr8, w_wc8;

    logic               w_cell_re, w_cell_we;
    logic [CAW-1:0]     w_cell_raddr, w_cell_waddr;
    logic [1:0]         w_cell_wmask, w_cell_wdata, w_cell_rdata;
    logic               w_stk_re, w_stk_we;
    logic [SAW-1:0]     w_stk_raddr, w_stk_waddr;
    dmc_pkg::t_coord    w_stk_wdata, w_stk_rdata;
    dmc_pkg::t_rsp_item w_rsp;

    dmc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dmc_cell_mem #(.DEPTH(CELLS), .AW(CAW)) u_cells (
        .i_clk   (i_clk),
        .i_re    (w_cell_re),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata),
        .i_we    (w_cell_we),
        .i_wmask (w_cell_wmask),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata)
    );

    dmc_stack_mem #(.DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .i_clk   (i_clk),
        .i_re    (w_stk_re),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata)
    );

    assign w_accept     = i_req.valid && i_req.ready;
    assign w_clr_last   = (r_clr == CAW'(CELLS - 1));
    assign w_out_load   = (r_state == dmc_pkg::ST_RESP) && (!r_out_valid || o_rsp.ready);
    assign w_q_in_store = (32'(r_qrow) < 32'(MAX_ROWS)) && (32'(r_qcol) < 32'(MAX_COLS));
    assign w_cnt_m1     = r_count - CNTW'(1);
    assign w_cnt_m2     = r_count - CNTW'(2);
    assign w_not_full   = (r_count < CNTW'(STACK_DEPTH));

    // neighbour coordinates and bounds of the current top
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_nb_row[k] = $signed({2'b00, r_top_row}) + dmc_pkg::STEP_DR[k];
            w_nb_col[k] = $signed({2'b00, r_top_col}) + dmc_pkg::STEP_DC[k];
            w_nb_ok[k]  = dmc_pkg::nb_ok(w_nb_row[k], w_nb_col[k], w_cfg.grid_rows,
                                         w_cfg.grid_cols, MAX_ROWS, MAX_COLS);
        end
    end

    // choose the candidate at random mod count, in east, west, south, north order
    always_comb begin
        logic [1:0] seen;
        logic       found;
        seen   = 2'd0;
        found  = 1'b0;
        w_cand = w_nb_ok & ~r_vis;
        w_n    = 3'($countones(w_cand));
        w_idx  = dmc_pkg::pick_index(r_rnd, w_n);
        w_pick = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (w_cand[k] && !found) begin
                if (seen == w_idx) begin
                    w_pick = 2'(k);
                    found  = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        w_adv          = (w_n != 3'd0) && w_not_full;
        w_wr8          = $signed({2'b00, r_top_row}) + dmc_pkg::WALL_DR[w_pick];
        w_wc8          = $signed({2'b00, r_top_col}) + dmc_pkg::WALL_DC[w_pick];
        w_new_wall_row = w_wr8[CW-1:0];
        w_new_wall_col = w_wc8[CW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmc_pkg::ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_clr_reply ? dmc_pkg::ST_RESP : dmc_pkg::ST_IDLE;
                end
            end
            dmc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_req.data.cmd)
                        dmc_pkg::CMD_RESTART: n_state = dmc_pkg::ST_CLEAR;
                        dmc_pkg::CMD_STEP: begin
                            n_state = (r_count != '0) ? dmc_pkg::ST_SCAN : dmc_pkg::ST_RESP;
                        end
                        dmc_pkg::CMD_READ: n_state = dmc_pkg::ST_QRY;
                        default:           n_state = dmc_pkg::ST_RESP;
                    endcase
                end
            end
            dmc_pkg::ST_SCAN: begin
                if (r_k == 2'd3) begin
                    n_state = dmc_pkg::ST_WAIT;
                end
            end
            dmc_pkg::ST_WAIT: n_state = dmc_pkg::ST_PICK;
            dmc_pkg::ST_PICK: n_state = dmc_pkg::ST_RESP;
            dmc_pkg::ST_QRY:  n_state = dmc_pkg::ST_RESP;
            dmc_pkg::ST_RESP: begin
                if (w_out_load) begin
                    n_state = dmc_pkg::ST_IDLE;
                end
            end
            default: n_state = dmc_pkg::ST_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        i_req.ready  = (r_state == dmc_pkg::ST_IDLE);
        w_cell_re    = 1'b0;
        w_cell_raddr = cell_addr(r_qrow, r_qcol);
        w_cell_we    = 1'b0;
        w_cell_wmask = 2'b00;
        w_cell_waddr = cell_addr(r_top_row, r_top_col);
        w_cell_wdata = 2'b00;
        w_stk_re     = 1'b0;
        w_stk_raddr  = w_cnt_m2[SAW-1:0];
        w_stk_we     = 1'b0;
        w_stk_waddr  = w_cnt_m1[SAW-1:0];
        w_stk_wdata  = '{row: r_top_row, col: r_top_col};
        case (r_state)
            dmc_pkg::ST_CLEAR: begin
                w_cell_we    = 1'b1;
                w_cell_wmask = 2'b11;
                w_cell_waddr = r_clr;
            end
            dmc_pkg::ST_SCAN: begin
                w_cell_re    = w_nb_ok[r_k];
                w_cell_raddr = cell_addr(w_nb_row[r_k][CW-1:0], w_nb_col[r_k][CW-1:0]);
                if (r_k == 2'd0) begin
                    // mark the top visited, fetch the entry below it for a pop
                    w_cell_we                     = 1'b1;
                    w_cell_wmask[dmc_pkg::VIS_BIT] = 1'b1;
                    w_cell_wdata[dmc_pkg::VIS_BIT] = 1'b1;
                    w_stk_re                      = (r_count >= CNTW'(2));
                end
            end
            dmc_pkg::ST_PICK: begin
                if (w_adv) begin
                    w_cell_we                        = 1'b1;
                    w_cell_wmask[dmc_pkg::CARVE_BIT] = 1'b1;
                    w_cell_wdata[dmc_pkg::CARVE_BIT] = 1'b1;
                    w_cell_waddr                     = cell_addr(w_new_wall_row,
                                                                 w_new_wall_col);
                    w_stk_we                         = 1'b1;
                end
            end
            dmc_pkg::ST_QRY: begin
                w_cell_re = w_q_in_store;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmc_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_k         <= 2'd0;
            r_top_row   <= CW'(1);
            r_top_col   <= CW'(1);
            r_count     <= CNTW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= w_out_load || (r_out_valid && !o_rsp.ready);
            case (r_state)
                dmc_pkg::ST_CLEAR: begin
                    r_clr <= w_clr_last ? '0 : r_clr + CAW'(1);
                end
                dmc_pkg::ST_IDLE: begin
                    r_k <= 2'd0;
                    if (w_accept && i_req.data.cmd == dmc_pkg::CMD_RESTART) begin
                        r_top_row   <= CW'(1);
                        r_top_col   <= CW'(1);
                        r_count     <= CNTW'(1);
                        r_clr       <= '0;
                        r_clr_reply <= 1'b1;
                    end
                end
                dmc_pkg::ST_SCAN: begin
                    r_k <= r_k + 2'd1;
                end
                dmc_pkg::ST_PICK: begin
                    if (w_adv) begin
                        r_top_row <= w_nb_row[w_pick][CW-1:0];
                        r_top_col <= w_nb_col[w_pick][CW-1:0];
                        r_count   <= r_count + CNTW'(1);
                    end else begin
                        r_count <= w_cnt_m1;
                        if (r_count >= CNTW'(2)) begin
                            r_top_row <= w_stk_rdata.row;
                            r_top_col <= w_stk_rdata.col;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // request payload, gathered neighbour marks and result fields
    always_ff @(posedge i_clk) begin
        case (r_state)
            dmc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_cmd      <= i_req.data.cmd;
                    r_rnd      <= i_req.data.random_value;
                    r_qrow     <= i_req.data.query_row;
                    r_qcol     <= i_req.data.query_col;
                    r_wall_row <= '0;
                    r_wall_col <= '0;
                    r_ev       <= (i_req.data.cmd == dmc_pkg::CMD_READ) ?
                                  dmc_pkg::EV_READ : dmc_pkg::EV_IDLE;
                end
            end
            dmc_pkg::ST_SCAN: begin
                if (r_k != 2'd0) begin
                    r_vis[r_k - 2'd1] <= w_cell_rdata[dmc_pkg::VIS_BIT];
                end
            end
            dmc_pkg::ST_WAIT: begin
                r_vis[3] <= w_cell_rdata[dmc_pkg::VIS_BIT];
            end
            dmc_pkg::ST_PICK: begin
                if (w_adv) begin
                    r_ev       <= dmc_pkg::EV_ADVANCE;
                    r_wall_row <= w_new_wall_row;
                    r_wall_col <= w_new_wall_col;
                end else begin
                    r_ev <= dmc_pkg::EV_BACK;
                end
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out <= w_rsp;
        end
    end

    always_comb begin
        w_rsp.event_res = r_ev;
        w_rsp.top_row   = (r_count != '0) ? r_top_row : '0;
        w_rsp.top_col   = (r_count != '0) ? r_top_col : '0;
        w_rsp.wall_row  = r_wall_row;
        w_rsp.wall_col  = r_wall_col;
        // odd row and odd column cells are open from the start, walls only once carved
        w_rsp.cell_open = (r_ev == dmc_pkg::EV_READ) && (r_cmd == dmc_pkg::CMD_READ)
                          && w_q_in_store
                          && ((r_qrow[0] && r_qcol[0]) || w_cell_rdata[dmc_pkg::CARVE_BIT]);
        w_rsp.done_res  = (r_count == '0);
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stk_we |-> (r_count < CNTW'(STACK_DEPTH)))
        else $error("stack push with no room");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dmc_pkg::ST_PICK && w_adv) |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("advance did not grow the stack");

    a_top_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_top_row[0] && r_top_col[0]))
        else $error("stack top is not a room cell");

    a_wall_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.event_res == dmc_pkg::EV_ADVANCE)
            |-> (o_rsp.data.wall_row[0] ^ o_rsp.data.wall_col[0]))
        else $error("carved cell is not a wall cell");

endmodule

// ----- test/dmc_carver_checker.sv -----
// dmc_carver_checker: watches the request, result and register ports of dfs_maze_carver,
// predicts each result from its own copy of the maze, stack and grid size, and compares
// depends on dmc_pkg and the channel interfaces in dmc_chan_if
module dmc_carver_checker #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dmc_req_if                          i_req_mon,
    dmc_rsp_if                          i_rsp_mon,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [dmc_pkg::PADDR_W-1:0] i_paddr,
    input  logic [dmc_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import dmc_pkg::*;

    logic [COORD_W-1:0] rows_cfg;
    logic [COORD_W-1:0] cols_cfg;
    bit                 open_map [MAX_ROWS][MAX_COLS];
    bit                 seen_map [MAX_ROWS][MAX_COLS];
    t_coord             path_stack [STACK_DEPTH];
    int                 path_depth;
    t_rsp_item          replies_due [$];
    int                 fails = 0;

    // fresh maze: odd/odd cells open, nothing visited, stack holds the start cell
    function automatic void load_start();
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                open_map[r][c] = r[0] & c[0];
                seen_map[r][c] = 1'b0;
            end
        end
        path_stack[0].row = 6'd1;
        path_stack[0].col = 6'd1;
        path_depth = 1;
    endfunction

    function automatic t_rsp_item advance_maze(input t_req_item req);
        t_rsp_item rsp;
        int        y;
        int        x;
        int        ny;
        int        nx;
        int        n;
        int        d;
        int        dirs [4];
        rsp = '0;
        rsp.event_res = EV_IDLE;
        case (req.cmd)
            CMD_RESTART: begin
                load_start();
            end
            CMD_STEP: begin
                if (path_depth > 0) begin
                    y = path_stack[path_depth-1].row;
                    x = path_stack[path_depth-1].col;
                    seen_map[y][x] = 1'b1;
                    n = 0;
                    // east, west, south, north; bounds follow the current grid size
                    for (int k = 0; k < 4; k++) begin
                        ny = y + int'(STEP_DR[k]);
                        nx = x + int'(STEP_DC[k]);
                        if (ny >= 1 && nx >= 1 && ny <= int'(rows_cfg) - 2
                            && nx <= int'(cols_cfg) - 2 && ny < MAX_ROWS && nx < MAX_COLS) begin
                            if (!seen_map[ny][nx]) begin
                                dirs[n] = k;
                                n++;
                            end
                        end
                    end
                    if (n > 0 && path_depth < STACK_DEPTH) begin
                        d  = dirs[int'(req.random_value) % n];
                        ny = y + int'(STEP_DR[d]);
                        nx = x + int'(STEP_DC[d]);
                        open_map[(y + ny) / 2][(x + nx) / 2] = 1'b1;
                        rsp.wall_row = 6'((y + ny) / 2);
                        rsp.wall_col = 6'((x + nx) / 2);
                        path_stack[path_depth].row = 6'(ny);
                        path_stack[path_depth].col = 6'(nx);
                        path_depth++;
                        rsp.event_res = EV_ADVANCE;
                    end else begin
                        path_depth--;
                        rsp.event_res = EV_BACK;
                    end
                end
            end
            CMD_READ: begin
                rsp.event_res = EV_READ;
                if (int'(req.query_row) < MAX_ROWS && int'(req.query_col) < MAX_COLS) begin
                    rsp.cell_open = open_map[req.query_row][req.query_col];
                end
            end
            default: begin
            end
        endcase
        if (path_depth > 0) begin
            rsp.top_row = path_stack[path_depth-1].row;
            rsp.top_col = path_stack[path_depth-1].col;
        end
        rsp.done_res = (path_depth == 0);
        return rsp;
    endfunction

    function automatic string describe_reply(input t_rsp_item r);
        return $sformatf("ev %0d top (%0d,%0d) wall (%0d,%0d) cell %0d done %0d",
                         r.event_res, r.top_row, r.top_col, r.wall_row, r.wall_col,
                         r.cell_open, r.done_res);
    endfunction

    always @(posedge i_clk) begin
        t_rsp_item want;
        t_rsp_item got;
        if (!i_rst_n) begin
            rows_cfg = GRID_RST;
            cols_cfg = GRID_RST;
            load_start();
            replies_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_GRID_ROWS) begin
                    rows_cfg = i_pwdata[COORD_W-1:0];
                end else begin
                    cols_cfg = i_pwdata[COORD_W-1:0];
                end
            end
            // results first: a request taken at this edge cannot have answered yet
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = i_rsp_mon.data;
                if (replies_due.size() == 0) begin
                    if (fails < 10) begin
                        $display("%0t: result with no request waiting: %s", $realtime,
                                 describe_reply(got));
                    end
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.event_res !== want.event_res || got.top_row !== want.top_row
                        || got.top_col !== want.top_col || got.wall_row !== want.wall_row
                        || got.wall_col !== want.wall_col || got.cell_open !== want.cell_open
                        || got.done_res !== want.done_res) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch, expected %s", $realtime,
                                     describe_reply(want));
                            $display("%0t:           actual   %s", $realtime,
                                     describe_reply(got));
                        end
                        fails++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                replies_due.insert(replies_due.size(), advance_maze(i_req_mon.data));
            end
        end
        o_fail_count <= fails;
        o_pending    <= replies_due.size();
    end

endmodule

// ----- test/dfs_maze_carver_tb.sv -----
// dfs_maze_carver_tb: stimulus and verdict for the depth-first maze carver
// drives requests, grid-size writes and result back-pressure; checking sits in dmc_carver_checker
// depends on dmc_pkg, dmc_chan_if, dfs_maze_carver and dmc_carver_checker
module dfs_maze_carver_tb;
    import dmc_pkg::*;

    localparam logic [1:0] CMD_NOP          = 2'd3;
    localparam int         WATCHDOG_LIMIT   = 20000;
    localparam int         LONG_HOLD_CYCLES = 400;
    localparam int         RANDOM_ITEMS     = 1700;
    localparam int         PHASES           = 14;
    localparam int         SETTLE_CYCLES    = 20;
    localparam int         SEND_GAP  [4]    = '{0, 59, 0, 9};
    localparam int         RSP_STALL [4]    = '{0, 0, 59, 9};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 send_gap_pct  = 0;
    int                 rsp_stall_pct = 0;
    int                 hold_orders   = 0;
    int                 holds_done    = 0;
    int                 hold_left     = 0;
    int                 quiet_cycles  = 0;

    dmc_req_if req_if ();
    dmc_rsp_if rsp_if ();

    dfs_maze_carver dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dmc_carver_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off whenever one is ordered
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (hold_orders != holds_done) begin
            holds_done = hold_orders;
            hold_left  = LONG_HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("dfs_maze_carver_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic t_req_item req_of(input logic [1:0] cmd, input logic [7:0] rnd,
                                         input logic [5:0] qr, input logic [5:0] qc);
        t_req_item item;
        item.cmd          = cmd;
        item.random_value = rnd;
        item.query_row    = qr;
        item.query_col    = qc;
        return item;
    endfunction

    task automatic offer(input t_req_item item);
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready) begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait for every outstanding request to be answered
    task automatic drain();
        req_if.valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (pending != 0);
    endtask

    task automatic write_grid(input logic sel, input logic [COORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(posedge clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        t_req_item item;
        int        phase_rows [PHASES];
        int        phase_cols [PHASES];
        int        per_phase;
        int        sent;
        int        pick;
        int        mode;

        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid: the start cell has no neighbour, so the first step empties the stack
        write_grid(REG_GRID_ROWS, 6'd3);
        write_grid(REG_GRID_COLS, 6'd3);
        offer(req_of(CMD_STEP, 8'd0, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'd255, 6'd63, 6'd63));
        offer(req_of(CMD_NOP, 8'd0, 6'd0, 6'd0));
        offer(req_of(CMD_READ, 8'd0, 6'd1, 6'd1));
        offer(req_of(CMD_READ, 8'd255, 6'd0, 6'd0));
        offer(req_of(CMD_READ, 8'd0, 6'd63, 6'd63));
        offer(req_of(CMD_READ, 8'd0, 6'd63, 6'd0));
        offer(req_of(CMD_READ, 8'd0, 6'd0, 6'd63));
        offer(req_of(CMD_RESTART, 8'd0, 6'd0, 6'd0));
        drain();

        // 5x5 maze: four cells, carved to completion and one step past it
        write_grid(REG_GRID_ROWS, 6'd5);
        write_grid(REG_GRID_COLS, 6'd5);
        offer(req_of(CMD_STEP, 8'd0, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'd255, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'hAA, 6'd0, 6'd0));
        offer(req_of(CMD_READ, 8'd0, 6'd1, 6'd2));
        offer(req_of(CMD_READ, 8'd0, 6'd2, 6'd1));
        offer(req_of(CMD_STEP, 8'd1, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'd2, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'd3, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'h80, 6'd0, 6'd0));
        offer(req_of(CMD_STEP, 8'h7F, 6'd0, 6'd0));
        drain();

        phase_rows = '{63, 63, 3, 7, 5, 11, 4, 0, 9, 31, 2, 15, 0, 0};
        phase_cols = '{63, 3, 63, 9, 5, 11, 6, 1, 13, 62, 63, 17, 0, 0};
        phase_rows[PHASES-2] = $urandom_range(63);
        phase_cols[PHASES-2] = $urandom_range(63);
        phase_rows[PHASES-1] = $urandom_range(63);
        phase_cols[PHASES-1] = $urandom_range(63);
        per_phase = RANDOM_ITEMS / PHASES;

        for (int p = 0; p < PHASES; p++) begin
            write_grid(REG_GRID_ROWS, 6'(phase_rows[p]));
            write_grid(REG_GRID_COLS, 6'(phase_cols[p]));
            mode = p % 4;
            send_gap_pct = SEND_GAP[mode];
            rsp_stall_pct <= RSP_STALL[mode];
            // every third phase carries on the previous carve under the new size
            if (p % 3 != 2) begin
                offer(req_of(CMD_RESTART, 8'($urandom), 6'($urandom), 6'($urandom)));
            end
            sent = 0;
            while (sent < per_phase) begin
                item.random_value = 8'($urandom);
                item.query_row    = 6'($urandom);
                item.query_col    = 6'($urandom);
                pick = $urandom_range(99);
                if (pick < 2) begin
                    item.cmd = CMD_RESTART;
                end else if (pick < 4) begin
                    item.cmd = CMD_NOP;
                end else if (pick < 16) begin
                    item.cmd = CMD_READ;
                end else begin
                    item.cmd = CMD_STEP;
                end
                if (p == 0 && sent == 8 && hold_orders == 0) begin
                    // results back up while requests keep coming
                    hold_orders <= hold_orders + 1;
                end
                offer(item);
                if (item.cmd != CMD_NOP) begin
                    sent++;
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("dfs_maze_carver_tb OK");
        end else begin
            $display("dfs_maze_carver_tb NOT OK");
        end
        $finish;
    end

endmodule
